// ===== sv/assert_macros.svh =====
// Assertion macros shared by the batch normalisation RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/bnia_pkg.sv =====
// Package for the batch normalisation block: payload structs, codes,
// defaults and saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bnia_pkg;

    localparam int DEF_MAX_CHANNELS = 1024;
    localparam int DEF_MAX_PLANE    = 65536;

    localparam int DW    = 48;  // variance sum width, Q32.16
    localparam int INVW  = 31;  // inverse root width
    localparam int PRODW = 66;  // shared multiplier product width

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_PLANE_SIZE    = 3'd1;
    localparam logic [2:0] CFG_CAFFE_MODE    = 3'd2;
    localparam logic [2:0] CFG_EPSILON       = 3'd3;
    localparam logic [2:0] CFG_RESCALE_RECIP = 3'd4;

    typedef struct packed {
        logic               op;
        logic [9:0]         channel_sel;
        logic signed [31:0] mean_val;
        logic [30:0]        variance_val;
        logic signed [31:0] gamma_val;
        logic signed [31:0] beta_val;
        logic signed [15:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [15:0] result;
        logic [9:0]         channel_index;
        logic               image_end;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic signed [PRODW-1:0] x);
        logic signed [31:0] r;
        if (x > $signed(PRODW'(64'h7FFF_FFFF)))
            r = 32'sh7FFF_FFFF;
        else if (x < -$signed(PRODW'(64'h8000_0000)))
            r = 32'sh8000_0000;
        else
            r = 32'(x);
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PRODW-1:0] x);
        logic signed [15:0] r;
        if (x > $signed(PRODW'(32'h7FFF)))
            r = 16'sh7FFF;
        else if (x < -$signed(PRODW'(32'h8000)))
            r = 16'sh8000;
        else
            r = 16'(x);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/batchnorm_inference_affine.sv =====
// Batch normalisation for inference: coefficient folding, per-channel
// scale/offset memories and the sample datapath. Depends on bnia_pkg,
// bnia_invsqrt and assert_macros.svh.
//
//  channel | signals                      | payload
//  in      | in_valid / in_ready          | in_data (bnia_pkg::in_t)
//  out     | out_valid / out_ready        | out_data (bnia_pkg::out_t)
//  cfg     | cfg_we                       | cfg_index, cfg_data
//
// A sample goes through accept with memory read, multiply, then the
// add/round/saturate into the output register.
// A load goes through accept, variance multiply, start, 49 division steps and
// 25 root steps in the inverse root unit, hand-over, three multiplies and the
// write (a zero variance sum skips the division and root steps).
// The output register holds a result while the next item is worked on;
// a second result waits in its last cycle until out_ready.
// Reset clears counters and control; the memories hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module batchnorm_inference_affine #(
    parameter int MAX_CHANNELS = bnia_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_PLANE    = bnia_pkg::DEF_MAX_PLANE
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bnia_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bnia_pkg::out_t      out_data,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import bnia_pkg::*;

    `include "assert_macros.svh"

    localparam int AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW  = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;
    localparam int CEW = ($clog2(MAX_CHANNELS + 1) > 11) ? $clog2(MAX_CHANNELS + 1) : 11;
    localparam int PEW = ($clog2(MAX_PLANE + 1) > 17) ? $clog2(MAX_PLANE + 1) : 17;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_VAR  = 11'b00000000010,
        ST_PREP = 11'b00000000100,
        ST_ROOT = 11'b00000001000,
        ST_SCL  = 11'b00000010000,
        ST_MS   = 11'b00000100000,
        ST_MSS  = 11'b00001000000,
        ST_OMUL = 11'b00010000000,
        ST_WR   = 11'b00100000000,
        ST_RD   = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } state_t;

    // configuration
    logic [10:0]  channel_count_reg;
    logic [16:0]  plane_size_reg;
    logic         caffe_mode_reg;
    logic [15:0]  epsilon_reg;
    logic [31:0]  rescale_recip_reg;

    state_t             state_reg, state_next;
    logic [AW-1:0]      ch_cnt_reg;
    logic [PW-1:0]      pos_cnt_reg;

    logic [9:0]               sel_reg;
    logic signed [31:0]       mean_reg, gamma_reg, beta_reg;
    logic [30:0]              var_reg;
    logic signed [15:0]       sample_reg;
    logic signed [31:0]       scale_reg, ms_reg;
    logic signed [PRODW-1:0]  prod_reg;
    logic [9:0]               meta_ch_reg;
    logic                     meta_end_reg;

    logic [31:0] scale_mem  [MAX_CHANNELS];
    logic [31:0] offset_mem [MAX_CHANNELS];
    logic signed [31:0] rd_scale_reg, rd_offset_reg;

    logic        out_valid_reg;
    out_t        out_data_reg;

    logic                     in_xfer, load_xfer, samp_xfer;
    logic                     rt_done;
    logic [INVW-1:0]          rt_inv;
    logic [DW-1:0]            d_next;
    logic signed [32:0]       mul_a, mul_b;
    logic                     mul_en;
    logic signed [PRODW-1:0]  acc;
    logic signed [31:0]       offset_next;
    logic                     wr_en;
    logic                     out_load;
    logic [CEW-1:0]           chans_eff, ch_inc;
    logic [PEW-1:0]           plane_eff, pos_inc;
    logic                     plane_last, image_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_xfer = in_xfer && (in_data.op == OP_LOAD);
    assign samp_xfer = in_xfer && (in_data.op == OP_SAMPLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 11'd1;
            plane_size_reg    <= 17'd1;
            caffe_mode_reg    <= 1'b0;
            epsilon_reg       <= 16'd1;
            rescale_recip_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[10:0];
                CFG_PLANE_SIZE:    plane_size_reg    <= cfg_data[16:0];
                CFG_CAFFE_MODE:    caffe_mode_reg    <= cfg_data[0];
                CFG_EPSILON:       epsilon_reg       <= cfg_data[15:0];
                CFG_RESCALE_RECIP: rescale_recip_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // effective limits and NCHW walk
    always_comb
    begin
        chans_eff = CEW'(channel_count_reg);
        if (chans_eff == '0)
            chans_eff = CEW'(1);
        else if (chans_eff > CEW'(MAX_CHANNELS))
            chans_eff = CEW'(MAX_CHANNELS);
        plane_eff = PEW'(plane_size_reg);
        if (plane_eff == '0)
            plane_eff = PEW'(1);
        else if (plane_eff > PEW'(MAX_PLANE))
            plane_eff = PEW'(MAX_PLANE);
        ch_inc     = CEW'(ch_cnt_reg) + CEW'(1);
        pos_inc    = PEW'(pos_cnt_reg) + PEW'(1);
        plane_last = (pos_inc >= plane_eff);
        image_last = plane_last && (ch_inc >= chans_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg  <= '0;
            pos_cnt_reg <= '0;
        end
        else if (samp_xfer)
        begin
            if (plane_last)
            begin
                pos_cnt_reg <= '0;
                ch_cnt_reg  <= image_last ? '0 : AW'(ch_inc);
            end
            else
                pos_cnt_reg <= PW'(pos_inc);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_xfer)
                    state_next = (32'(in_data.channel_sel) < MAX_CHANNELS) ? ST_VAR : ST_IDLE;
                else if (samp_xfer)
                    state_next = ST_RD;
            end
            ST_VAR:  state_next = ST_PREP;
            ST_PREP: state_next = ST_ROOT;
            ST_ROOT: state_next = rt_done ? ST_SCL : ST_ROOT;
            ST_SCL:  state_next = ST_MS;
            ST_MS:   state_next = ST_MSS;
            ST_MSS:  state_next = ST_OMUL;
            ST_OMUL: state_next = ST_WR;
            ST_WR:   state_next = ST_IDLE;
            ST_RD:   state_next = ST_OUT;
            ST_OUT:  state_next = out_load ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capture item fields; caffe mode forces gamma to one and beta to zero
    always_ff @(posedge clk)
    begin
        if (load_xfer)
        begin
            sel_reg   <= in_data.channel_sel;
            mean_reg  <= in_data.mean_val;
            var_reg   <= in_data.variance_val;
            gamma_reg <= caffe_mode_reg ? 32'sh0001_0000 : in_data.gamma_val;
            beta_reg  <= caffe_mode_reg ? 32'sh0 : in_data.beta_val;
        end
        if (samp_xfer)
        begin
            sample_reg   <= in_data.sample;
            meta_ch_reg  <= 10'(ch_cnt_reg);
            meta_end_reg <= image_last;
        end
    end

    // shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        case (state_reg)
            ST_VAR:
            begin
                mul_a = $signed({2'b00, var_reg});
                mul_b = $signed({1'b0, rescale_recip_reg});
            end
            ST_SCL:
            begin
                mul_a = 33'(gamma_reg);
                mul_b = $signed({2'b00, rt_inv});
            end
            ST_MS:
            begin
                mul_a = 33'(mean_reg);
                mul_b = $signed({1'b0, rescale_recip_reg});
            end
            ST_OMUL:
            begin
                mul_a = 33'(ms_reg);
                mul_b = 33'(scale_reg);
            end
            ST_RD:
            begin
                mul_a = 33'(sample_reg);
                mul_b = 33'(rd_scale_reg);
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= PRODW'(mul_a) * PRODW'(mul_b);
        if (state_reg == ST_MS)
            scale_reg <= sat32(prod_reg >>> 16);
        if (state_reg == ST_MSS)
            ms_reg <= sat32(prod_reg >>> 16);
    end

    assign d_next = DW'(prod_reg[62:16]) + DW'(epsilon_reg);

    bnia_invsqrt u_invsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_PREP),
        .d     (d_next),
        .done  (rt_done),
        .inv   (rt_inv)
    );

    assign offset_next = sat32(PRODW'(beta_reg) - (prod_reg >>> 16));
    assign wr_en       = (state_reg == ST_WR);

    // coefficient memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            scale_mem[AW'(sel_reg)]  <= scale_reg;
            offset_mem[AW'(sel_reg)] <= offset_next;
        end
        if (samp_xfer)
        begin
            rd_scale_reg  <= scale_mem[ch_cnt_reg];
            rd_offset_reg <= offset_mem[ch_cnt_reg];
        end
    end

    // round half up from Q8.24 to Q8.8
    assign acc      = prod_reg + (PRODW'(rd_offset_reg) <<< 8) + PRODW'(32'sd32768);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.result        <= sat16(acc >>> 16);
            out_data_reg.channel_index <= meta_ch_reg;
            out_data_reg.image_end     <= meta_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMP(a_root_done_in_wait, clk, rst_n, rt_done, state_reg == ST_ROOT)
    `ASSERT_NXT(a_sample_reads, clk, rst_n, samp_xfer, state_reg == ST_RD)
    `ASSERT_NXT(a_load_no_result, clk, rst_n, load_xfer && !out_valid_reg, !out_valid_reg)
    `ASSERT_IMP(a_mem_ports_apart, clk, rst_n, wr_en, !in_ready)

endmodule

`default_nettype wire

// ===== sv/bnia_invsqrt.sv =====
// Iterative inverse square root: floor(sqrt(floor(2^48 / d))), one
// division bit then one root bit per cycle. Depends on bnia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnia_invsqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bnia_pkg::DW-1:0]     d,
    output logic                             done,
    output logic [bnia_pkg::INVW-1:0]        inv
);
    import bnia_pkg::*;

    typedef enum logic [2:0] {
        RS_IDLE = 3'b001,
        RS_DIV  = 3'b010,
        RS_SQRT = 3'b100
    } rs_state_t;

    rs_state_t        state_reg;
    logic [5:0]       cnt_reg;
    logic [DW-1:0]    dvs_reg;
    logic [DW:0]      rem_reg;
    logic [DW+1:0]    q_reg;
    logic [25:0]      srem_reg;
    logic [24:0]      root_reg;
    logic [INVW-1:0]  inv_reg;
    logic             done_reg;

    logic [DW:0]      rem_shift;
    logic             q_bit;
    logic [DW:0]      rem_next;
    logic [27:0]      s_shift;
    logic [27:0]      trial;
    logic             r_bit;
    logic [25:0]      srem_next;
    logic [24:0]      root_next;

    always_comb
    begin
        // dividend is 2^48: its only set bit enters on the first step
        rem_shift = {rem_reg[DW-1:0], (cnt_reg == 6'(DW))};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = q_bit ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
        s_shift   = {srem_reg, q_reg[DW+1:DW]};
        trial     = {1'b0, root_reg, 2'b01};
        r_bit     = (s_shift >= trial);
        srem_next = r_bit ? 26'(s_shift - trial) : 26'(s_shift);
        root_next = {root_reg[23:0], r_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                RS_IDLE:
                begin
                    if (start)
                    begin
                        if (d == '0)
                            done_reg <= 1'b1;
                        else
                            state_reg <= RS_DIV;
                    end
                end
                RS_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= RS_SQRT;
                end
                RS_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= RS_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                    state_reg <= RS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    cnt_reg <= 6'(DW);
                    dvs_reg <= d;
                    rem_reg <= '0;
                    q_reg   <= '0;
                    if (d == '0)
                        inv_reg <= {INVW{1'b1}};
                end
            end
            RS_DIV:
            begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[DW:0], q_bit};
                if (cnt_reg == '0)
                begin
                    cnt_reg  <= 6'd24;
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end
            RS_SQRT:
            begin
                srem_reg <= srem_next;
                root_reg <= root_next;
                q_reg    <= {q_reg[DW-1:0], 2'b00};
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    inv_reg <= INVW'(root_next);
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign inv  = inv_reg;

endmodule

`default_nettype wire

// ===== test/bnia_checker.sv =====
// Checker for the batch normalisation block: folds coefficient loads, predicts each
// sample result and compares it with the output transfer. Depends on bnia_pkg.
`timescale 1ns / 1ps

module bnia_checker
    import bnia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire in_t         in_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire out_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               pending,
    output int               errors
);

    logic signed [31:0] scale_mem [1024];
    logic signed [31:0] offset_mem [1024];
    logic [9:0]         chan_pos;
    logic [15:0]        plane_pos;
    logic [10:0]        chan_count_reg;
    logic [16:0]        plane_size_reg;
    logic               caffe_reg;
    logic [15:0]        eps_reg;
    logic [31:0]        recip_reg;
    out_t               norm_queue [$];

    assign pending = norm_queue.size();

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000)
            return -64'sh8000_0000;
        return x;
    endfunction

    // Fold one channel's statistics into scale and offset
    task automatic fold_coeffs(input in_t it);
        longint unsigned vsum;
        longint unsigned inv;
        longint g, b, m, sc, ms;
        vsum = ((64'(it.variance_val) * 64'(recip_reg)) >> 16) + 64'(eps_reg);
        inv = (vsum == 0) ? 64'h7FFF_FFFF : int_sqrt((64'd1 << 48) / vsum);
        if (inv > 64'h7FFF_FFFF)
            inv = 64'h7FFF_FFFF;
        g = caffe_reg ? 64'sd65536 : longint'(it.gamma_val);
        b = caffe_reg ? 64'sd0 : longint'(it.beta_val);
        m = longint'(it.mean_val);
        sc = clamp32((g * longint'(inv)) >>> 16);
        ms = clamp32((m * longint'({32'd0, recip_reg})) >>> 16);
        scale_mem[it.channel_sel] = 32'(sc);
        offset_mem[it.channel_sel] = 32'(clamp32(b - ((ms * sc) >>> 16)));
    endtask

    task automatic predict_norm(input in_t it);
        int unsigned chans, plane;
        longint acc;
        logic plane_last;
        out_t o;
        chans = (chan_count_reg == 0) ? 1 : (chan_count_reg > 1024 ? 1024 : chan_count_reg);
        plane = (plane_size_reg == 0) ? 1 : (plane_size_reg > 65536 ? 65536 : plane_size_reg);
        acc = longint'(it.sample) * longint'(scale_mem[chan_pos])
            + longint'(offset_mem[chan_pos]) * 256 + 32768;
        acc = acc >>> 16;
        o.result = (acc > 32767) ? 16'sh7FFF : (acc < -32768 ? 16'sh8000 : 16'(acc));
        o.channel_index = chan_pos;
        plane_last = (32'(plane_pos) + 1) >= plane;
        o.image_end = plane_last && ((32'(chan_pos) + 1) >= chans);
        norm_queue.push_back(o);
        if (plane_last)
        begin
            plane_pos <= '0;
            chan_pos <= ((32'(chan_pos) + 1) >= chans) ? '0 : chan_pos + 1'b1;
        end
        else
            plane_pos <= plane_pos + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_pos       <= '0;
            plane_pos      <= '0;
            chan_count_reg <= 11'd1;
            plane_size_reg <= 17'd1;
            caffe_reg      <= 1'b0;
            eps_reg        <= 16'd1;
            recip_reg      <= 32'd65536;
            errors         <= 0;
            norm_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[10:0];
                    CFG_PLANE_SIZE:    plane_size_reg <= cfg_data[16:0];
                    CFG_CAFFE_MODE:    caffe_reg      <= cfg_data[0];
                    CFG_EPSILON:       eps_reg        <= cfg_data[15:0];
                    CFG_RESCALE_RECIP: recip_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (in_data.op == OP_LOAD)
                    fold_coeffs(in_data);
                else
                    predict_norm(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (norm_queue.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, actual %h", $time, out_data);
                    errors <= errors + 1;
                end
                else if (norm_queue[0] !== out_data)
                begin
                    $display("%0t: mismatch result exp %0d act %0d, channel exp %0d act %0d, end exp %0b act %0b",
                        $time, norm_queue[0].result, out_data.result,
                        norm_queue[0].channel_index, out_data.channel_index,
                        norm_queue[0].image_end, out_data.image_end);
                    errors <= errors + 1;
                    void'(norm_queue.pop_front());
                end
                else
                    void'(norm_queue.pop_front());
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the batch normalisation testbench: clock, reset, register settings and
// stimulus with random idling. Depends on bnia_pkg, bnia_checker and the block.
`timescale 1ns / 1ps

module tb_top;
    import bnia_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          pending;
    int          errors;
    int          cycles = 0;
    int          src_idle = 21;
    int          sink_idle = 78;
    int          n_loads = 0;
    int          n_samples = 0;
    bit          loaded [1024];

    batchnorm_inference_affine u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bnia_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_idle);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input in_t it);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        if (it.op == OP_LOAD)
        begin
            n_loads++;
            loaded[it.channel_sel] = 1'b1;
        end
        else
            n_samples++;
    endtask

    function automatic in_t load_item(input logic [9:0] ch);
        in_t it;
        it.op = OP_LOAD;
        it.channel_sel = ch;
        it.mean_val = $urandom;
        it.variance_val = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(65536 * 8));
        it.gamma_val = $urandom;
        it.beta_val = $urandom;
        it.sample = $urandom;
        return it;
    endfunction

    function automatic in_t sample_item(input logic signed [15:0] x);
        in_t it;
        it = load_item(10'($urandom));
        it.op = OP_SAMPLE;
        it.sample = x;
        return it;
    endfunction

    // Hold until every result is out and a load can no longer be in flight
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] cc, input logic [31:0] ps, input logic cm,
                              input logic [31:0] eps, input logic [31:0] rr);
        logic [31:0] vals [5];
        int chans;
        vals = '{cc, ps, 32'(cm), eps, rr};
        wait_quiet();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        // every channel the counter can reach must hold coefficients first
        chans = (cc[10:0] == 0) ? 1 : (cc[10:0] > 1024 ? 1024 : cc[10:0]);
        for (int c = 0; c < chans; c++)
            if (!loaded[c])
                send(load_item(10'(c)));
    endtask

    initial
    begin
        in_t it;
        logic [31:0] cc_set [6];
        logic [31:0] ps_set [6];
        logic [31:0] eps_set [6];
        logic [31:0] rr_set [6];
        logic        cm_set [6];
        logic signed [15:0] edge_vals [6];

        cc_set  = '{0, 1024, 2047, 3, 7, 16};
        ps_set  = '{0, 5, 1, 131071, 4, 65536};
        cm_set  = '{1, 0, 1, 0, 0, 1};
        eps_set = '{65535, 1, 0, 100, $urandom_range(65535), 2};
        rr_set  = '{0, 65536, 32'hFFFF_FFFF, $urandom, $urandom, 131072};
        edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh0100};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero variance sum with eps 0, field extremes, image ends
        write_regs(4, 3, 0, 0, 65536);
        it = load_item(0);
        it.variance_val = '0;
        it.mean_val = 32'sh7FFF_FFFF;
        it.gamma_val = 32'sh7FFF_FFFF;
        it.beta_val = 32'sh8000_0000;
        send(it);
        it = load_item(1);
        it.variance_val = 31'h7FFF_FFFF;
        it.mean_val = 32'sh8000_0000;
        it.gamma_val = 32'sh8000_0000;
        it.beta_val = 32'sh7FFF_FFFF;
        send(it);
        for (int i = 0; i < 12; i++)
            send(sample_item(edge_vals[i % 6]));
        write_regs(1023, 65535, 1, 65535, 32'hFFFF_FFFF);
        send(load_item(10'h3FF));
        for (int i = 0; i < 6; i++)
            send(sample_item(edge_vals[i]));

        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                src_idle = 78;
                sink_idle = 21;
            end
            else if (p == 4)
            begin
                src_idle = 0;
                sink_idle = 0;
            end
            write_regs(cc_set[p], ps_set[p], cm_set[p], eps_set[p], rr_set[p]);
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(9) == 0)
                    send(load_item(10'($urandom)));
                else if ($urandom_range(15) == 0)
                    send(sample_item(edge_vals[$urandom_range(5)]));
                else
                    send(sample_item(16'($urandom)));
                if (i == 40)
                    wait_quiet();
            end
        end

        wait_quiet();
        $display("covered %0d coefficient loads and %0d samples over eight register settings",
                 n_loads, n_samples);
        $display("idling patterns: sender heavy, receiver heavy and none");
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
